/* hw/rtl/channel_latency_statistics_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the channel latency statistics block
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_LATENCY_STATISTICS_DEFINES_SVH
`define CHANNEL_LATENCY_STATISTICS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cls_pkg.sv */
// ----------------------------------------------------------------------------
// cls_pkg
// Types and constants for the channel latency statistics block.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int NUM_CH = 8;
  localparam int CH_W   = 3;
  localparam int CMD_W  = 3;
  localparam int TIME_W = 32;
  localparam int SUM_W  = 48;

  localparam logic [CMD_W-1:0] CMD_START     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET_CH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET_ALL = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] timestamp;
  } cls_in_t;

  typedef struct packed {
    logic              ok;
    logic [TIME_W-1:0] sample_count;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] min_time;
    logic [TIME_W-1:0] max_time;
    logic [TIME_W-1:0] avg_time;
    logic [SUM_W-1:0]  total_time;
    logic              running;
  } cls_out_t;

  // Per-channel record kept in the statistics RAM.
  typedef struct packed {
    logic [TIME_W-1:0] start_stamp;
    logic              open_flag;
    logic [TIME_W-1:0] done_count;
    logic [TIME_W-1:0] recent_elapsed;
    logic [TIME_W-1:0] least_elapsed;
    logic [TIME_W-1:0] most_elapsed;
    logic [SUM_W-1:0]  elapsed_sum;
  } cls_rec_t;

  localparam int REC_W = $bits(cls_rec_t);

endpackage

/* hw/rtl/cls_ram.sv */
// ----------------------------------------------------------------------------
// cls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/cls_div.sv */
// ----------------------------------------------------------------------------
// cls_div
// Restoring divider: sum-width dividend by time-width divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module cls_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [cls_pkg::SUM_W-1:0]  dividend,
  input  logic [cls_pkg::TIME_W-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic [cls_pkg::SUM_W-1:0]  quotient
);
  import cls_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dsr});
  assign busy  = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !busy) begin
        cnt <= CNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      // shift the next dividend bit into the remainder, keep the quotient bit
      rem      <= fits ? TIME_W'(trial - {1'b0, dsr}) : trial[TIME_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

/* hw/rtl/channel_latency_statistics.sv */
// ----------------------------------------------------------------------------
// channel_latency_statistics
// Per-channel latency profiler: start/end timing, statistics and queries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive item (command, channel, timestamp) with start high; the item is
//   taken on a rising edge where busy is low. Exactly one result follows,
//   shown on result for one cycle with done high. The receiver cannot stall.
//   cfg_wen/cfg_wdata write the channel enable mask while the block is idle.
// Answers:
//   Reset-all, unknown commands and disabled channels answer in the cycle after they are taken.
//   Other commands step through load, elapsed, update and write-back, and
//   then wait on the 48-step average divider when the channel has samples.
//   The next item may be accepted in the cycle done is high.
// Reset:
//   rst clears the enable mask and the per-entry valid bits; an entry that
//   is not valid reads as an all-zero record, so no clearing pass is needed.
//   Reset-all clears the valid bits the same way.
// Storage:
//   One channel record lives in an 8-entry RAM with a registered read;
//   accesses are serialized by busy, so reads never overlap a write-back.
// ----------------------------------------------------------------------------
`include "channel_latency_statistics_defines.svh"

module channel_latency_statistics (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cls_pkg::cls_in_t           item,
  output logic                       done,
  output cls_pkg::cls_out_t          result,
  input  logic                       cfg_wen,
  input  logic [cls_pkg::NUM_CH-1:0] cfg_wdata
);
  import cls_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_ELAP = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [2:0]        state;
  logic [NUM_CH-1:0] enable;
  logic [NUM_CH-1:0] valid;
  logic [CMD_W-1:0]  cmd;
  logic [CH_W-1:0]   ch;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] elapsed;
  logic              ok;
  cls_rec_t          rec;
  cls_rec_t          rec_next;
  logic              ok_next;
  logic [REC_W-1:0]  rdata;
  logic              accept;
  logic              direct;
  logic              div_go;
  logic              div_busy;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [TIME_W-1:0] avg;
  logic [SUM_W:0]    sum_ext;
  logic              emit;
  cls_out_t          report;
  cls_out_t          direct_report;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  // commands answered without updating the RAM
  assign direct = (item.command > CMD_RESET_ALL) || (item.command == CMD_RESET_ALL) ||
                  !enable[item.channel];

  cls_ram #(
    .WIDTH(REC_W),
    .DEPTH(NUM_CH)
  ) u_ram (
    .clk  (clk),
    .we   (state == S_WB),
    .waddr(ch),
    .wdata(rec),
    .re   (accept),
    .raddr(item.channel),
    .rdata(rdata)
  );

  assign div_go = (state == S_WB) && (rec.done_count != '0);

  cls_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(rec.elapsed_sum),
    .divisor (rec.done_count),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(quotient)
  );

  // Statistics update for the command in hand.
  always_comb begin
    rec_next = rec;
    ok_next  = 1'b1;
    sum_ext  = {1'b0, rec.elapsed_sum} + (SUM_W + 1)'(elapsed);
    case (cmd)
      CMD_START: begin
        rec_next.start_stamp = stamp;
        rec_next.open_flag   = 1'b1;
      end
      CMD_END: begin
        if (rec.open_flag) begin
          rec_next.recent_elapsed = elapsed;
          rec_next.elapsed_sum    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          if (rec.done_count == '0) begin
            rec_next.least_elapsed = elapsed;
            rec_next.most_elapsed  = elapsed;
          end else begin
            if (elapsed < rec.least_elapsed) begin
              rec_next.least_elapsed = elapsed;
            end
            if (elapsed > rec.most_elapsed) begin
              rec_next.most_elapsed = elapsed;
            end
          end
          if (rec.done_count != '1) begin
            rec_next.done_count = rec.done_count + 1'b1;
          end
          rec_next.open_flag = 1'b0;
        end else begin
          ok_next = 1'b0;
        end
      end
      CMD_RESET_CH: begin
        rec_next = '0;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  // Saturate the average to the time width.
  assign avg = (rec.done_count == '0) ? '0 :
               ((quotient >> TIME_W) != '0) ? '1 : quotient[TIME_W-1:0];

  always_comb begin
    report              = '0;
    report.ok           = ok;
    report.sample_count = rec.done_count;
    report.last_time    = rec.recent_elapsed;
    report.min_time     = (rec.done_count == '0) ? '0 : rec.least_elapsed;
    report.max_time     = (rec.done_count == '0) ? '0 : rec.most_elapsed;
    report.avg_time     = avg;
    report.total_time   = rec.elapsed_sum;
    report.running      = rec.open_flag;
  end

  always_comb begin
    direct_report    = '0;
    direct_report.ok = (item.command == CMD_RESET_ALL);
  end

  assign emit = ((state == S_WB) && (rec.done_count == '0)) ||
                ((state == S_DIV) && div_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      enable <= '0;
      valid  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wen) begin
        enable <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (direct) begin
              done <= 1'b1;
              if (item.command == CMD_RESET_ALL) begin
                valid <= '0;
              end
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: state <= S_ELAP;
        S_ELAP: state <= S_UPD;
        S_UPD:  state <= S_WB;
        S_WB: begin
          valid[ch] <= 1'b1;
          if (emit) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (emit) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= item.command;
      ch    <= item.channel;
      stamp <= item.timestamp;
      if (direct) begin
        result <= direct_report;
      end
    end
    if (state == S_LOAD) begin
      // an entry never written since reset reads as zero
      rec <= valid[ch] ? cls_rec_t'(rdata) : '0;
    end
    if (state == S_ELAP) begin
      elapsed <= stamp - rec.start_stamp;
    end
    if (state == S_UPD) begin
      rec <= rec_next;
      ok  <= ok_next;
    end
    if (emit) begin
      result <= report;
    end
  end

  `CLS_ASSERT_SAME(a_done_has_cause, done, $past(start || busy), "result without an item")
  `CLS_ASSERT_NEXT(a_reset_all_answer, accept && (item.command == CMD_RESET_ALL),
                   done && result.ok && !busy, "reset-all did not answer at once")
  `CLS_ASSERT_SAME(a_div_idle_on_go, div_go, !div_busy, "divider started while busy")
  `CLS_ASSERT_SAME(a_div_only_waiting, div_busy, state == S_DIV, "divider runs outside wait")

endmodule

/* dv/channel_latency_statistics_checker.sv */
// ----------------------------------------------------------------------------
// Channel latency statistics checker
// Watches the item, result and enable-mask ports, keeps its own per-channel
// statistics, and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module channel_latency_statistics_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  cls_pkg::cls_in_t           item,
  input  logic                       done,
  input  cls_pkg::cls_out_t          result,
  input  logic                       cfg_wen,
  input  logic [cls_pkg::NUM_CH-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         pending,
  output int                         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  logic [NUM_CH-1:0] enable_mask;
  logic [TIME_W-1:0] t_start [NUM_CH];
  logic              is_open [NUM_CH];
  logic [TIME_W-1:0] n_done  [NUM_CH];
  logic [TIME_W-1:0] e_last  [NUM_CH];
  logic [TIME_W-1:0] e_min   [NUM_CH];
  logic [TIME_W-1:0] e_max   [NUM_CH];
  logic [SUM_W-1:0]  e_sum   [NUM_CH];

  cls_out_t stats_due [$];
  cls_out_t due;

  function automatic void clear_slot(input int ch);
    t_start[ch] = '0;
    is_open[ch] = 1'b0;
    n_done[ch]  = '0;
    e_last[ch]  = '0;
    e_min[ch]   = '0;
    e_max[ch]   = '0;
    e_sum[ch]   = '0;
  endfunction

  // Apply one item to the channel statistics and return what it reports.
  function automatic cls_out_t latency_outcome(input cls_in_t it);
    cls_out_t          r;
    int                ch;
    logic [TIME_W-1:0] elapsed;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  quotient;
    r  = '0;
    ch = int'(it.channel);
    if (it.command == CMD_RESET_ALL) begin
      for (int c = 0; c < NUM_CH; c++) clear_slot(c);
      r.ok = 1'b1;
      return r;
    end
    if (it.command > CMD_RESET_ALL || !enable_mask[ch]) return r;
    case (it.command)
      CMD_START: begin
        t_start[ch] = it.timestamp;
        is_open[ch] = 1'b1;
        r.ok = 1'b1;
      end
      CMD_END: begin
        if (is_open[ch]) begin
          elapsed    = it.timestamp - t_start[ch];
          e_last[ch] = elapsed;
          sum_wide   = {1'b0, e_sum[ch]} + elapsed;
          e_sum[ch]  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
          if (n_done[ch] == '0) begin
            e_min[ch] = elapsed;
            e_max[ch] = elapsed;
          end else begin
            if (elapsed < e_min[ch]) e_min[ch] = elapsed;
            if (elapsed > e_max[ch]) e_max[ch] = elapsed;
          end
          // hold the count at its ceiling
          if (n_done[ch] != '1) n_done[ch] = n_done[ch] + 1'b1;
          is_open[ch] = 1'b0;
          r.ok = 1'b1;
        end
      end
      CMD_QUERY: r.ok = 1'b1;
      default: begin
        clear_slot(ch);
        r.ok = 1'b1;
      end
    endcase
    r.sample_count = n_done[ch];
    r.last_time    = e_last[ch];
    r.total_time   = e_sum[ch];
    r.running      = is_open[ch];
    if (n_done[ch] != '0) begin
      quotient   = e_sum[ch] / {{(SUM_W-TIME_W){1'b0}}, n_done[ch]};
      r.min_time = e_min[ch];
      r.max_time = e_max[ch];
      r.avg_time = (|quotient[SUM_W-1:TIME_W]) ? '1 : quotient[TIME_W-1:0];
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      enable_mask = '0;
      for (int c = 0; c < NUM_CH; c++) clear_slot(c);
      stats_due.delete();
    end else begin
      if (cfg_wen) enable_mask = cfg_wdata;
      if (done) begin
        if (stats_due.size() == 0) begin
          mismatches++;
          $error("result with no item outstanding");
        end else begin
          due = stats_due.pop_front();
          results_checked++;
          compare_field("ok", due.ok, result.ok);
          compare_field("sample_count", due.sample_count, result.sample_count);
          compare_field("last_time", due.last_time, result.last_time);
          compare_field("min_time", due.min_time, result.min_time);
          compare_field("max_time", due.max_time, result.max_time);
          compare_field("avg_time", due.avg_time, result.avg_time);
          compare_field("total_time", due.total_time, result.total_time);
          compare_field("running", due.running, result.running);
        end
      end
      // the block may take a new item in the same cycle a result leaves
      if (start && !busy) stats_due.insert(stats_due.size(), latency_outcome(item));
    end
    pending <= stats_due.size();
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Channel latency statistics testbench
// Drives start/end/query/reset items with random gaps across several channel
// enable masks; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_RESET_ALL + 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int PHASE_ITEMS    = 185;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  cls_in_t           item      = '0;
  logic              cfg_wen   = 1'b0;
  logic [NUM_CH-1:0] cfg_wdata = '0;
  logic              busy;
  logic              done;
  cls_out_t          result;

  int mismatches;
  int pending;
  int results_checked;

  logic [NUM_CH-1:0] cur_mask = '0;
  logic [NUM_CH-1:0] phase_mask;
  logic [TIME_W-1:0] open_ts [NUM_CH];
  logic              steady = 1'b0;
  int                items_sent = 0;
  int                items_counted = 0;
  int                mask_writes = 0;
  int                target;
  int                idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  channel_latency_statistics DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  channel_latency_statistics_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .item            (item),
    .done            (done),
    .result          (result),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Present one item, maybe after a random gap, and hold it until taken.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                       input logic [TIME_W-1:0] ts);
    cls_in_t     it;
    logic [63:0] noise;
    int          gap;
    it.command   = cmd;
    it.channel   = ch;
    it.timestamp = ts;
    if (!steady && $urandom_range(99) < 22) begin
      gap   = ($urandom_range(9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 5);
      noise = {$urandom, $urandom};
      start <= 1'b0;
      item  <= noise[$bits(cls_in_t)-1:0];
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    items_sent++;
    if (cmd == CMD_RESET_ALL || (cmd < CMD_UNUSED_FIRST && cur_mask[ch])) items_counted++;
    if (cmd == CMD_START && cur_mask[ch]) open_ts[ch] = ts;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_mask(input logic [NUM_CH-1:0] mask);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    cur_mask = mask;
    mask_writes++;
  endtask

  // Mostly start/end pairs on enabled channels, with queries and some noise.
  task automatic random_item();
    logic [CH_W-1:0]   ch;
    logic [TIME_W-1:0] elapsed;
    int                roll;
    ch = CH_W'($urandom_range(NUM_CH - 1));
    if (cur_mask != '0 && $urandom_range(9) != 0) begin
      while (!cur_mask[ch]) ch = CH_W'($urandom_range(NUM_CH - 1));
    end
    roll = $urandom_range(99);
    if (roll < 36) begin
      issue(CMD_START, ch, $urandom);
    end else if (roll < 72) begin
      roll = $urandom_range(99);
      if (roll < 50)      elapsed = $urandom_range(0, 2000);
      else if (roll < 85) elapsed = $urandom;
      else if (roll < 95) elapsed = '0;
      else                elapsed = '1;
      issue(CMD_END, ch, open_ts[ch] + elapsed);
    end else if (roll < 89) begin
      issue(CMD_QUERY, ch, $urandom);
    end else if (roll < 94) begin
      issue(CMD_RESET_CH, ch, $urandom);
    end else if (roll < 95) begin
      issue(CMD_RESET_ALL, ch, $urandom);
    end else begin
      issue(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), ch, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CH; c++) open_ts[c] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all channels disabled out of reset
    issue(CMD_QUERY, 3'd0, $urandom);
    issue(CMD_START, 3'd3, 32'h1234_5678);
    set_mask('1);
    // widest elapsed, then a wrap through zero
    issue(CMD_START, 3'd0, '0);
    issue(CMD_END, 3'd0, '1);
    issue(CMD_START, 3'd0, '1);
    issue(CMD_END, 3'd0, '0);
    // restart overwrites the stamp; zero elapsed; end with nothing open
    issue(CMD_START, 3'd7, 32'd5);
    issue(CMD_START, 3'd7, 32'd100);
    issue(CMD_END, 3'd7, 32'd100);
    issue(CMD_END, 3'd7, 32'd200);
    issue(CMD_QUERY, 3'd0, $urandom);
    issue(CMD_QUERY, 3'd7, $urandom);
    issue(CMD_RESET_CH, 3'd0, $urandom);
    issue(CMD_QUERY, 3'd0, $urandom);
    issue(CMD_UNUSED_FIRST, 3'd1, $urandom);
    issue(CMD_UNUSED_LAST, 3'd6, '1);
    // state of a disabled channel must survive until it is enabled again
    issue(CMD_START, 3'd2, 32'hAAAA_5555);
    set_mask(8'hFB);
    issue(CMD_END, 3'd2, $urandom);
    issue(CMD_QUERY, 3'd2, $urandom);
    set_mask('1);
    issue(CMD_QUERY, 3'd2, $urandom);
    issue(CMD_END, 3'd2, 32'h5555_AAAA);
    issue(CMD_RESET_ALL, 3'd5, $urandom);
    issue(CMD_QUERY, 3'd7, $urandom);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: phase_mask = '1;
        1: phase_mask = 8'h80;
        3: phase_mask = 8'h01;
        5: phase_mask = '1;
        default: phase_mask = 8'($urandom_range(1, 254));
      endcase
      set_mask(phase_mask);
      steady = (p == 2);
      target = items_counted + PHASE_ITEMS;
      while (items_counted < target) random_item();
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d on enabled channels or reset-all) over %0d mask settings",
             items_sent, items_counted, mask_writes);
    $display("%0d results compared, %0d mismatching fields", results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/cls_pkg.sv
hw/rtl/cls_ram.sv
hw/rtl/cls_div.sv
hw/rtl/channel_latency_statistics.sv
dv/channel_latency_statistics_checker.sv
dv/tb.sv
